// ===== rtl/kwm_pkg.sv =====
// Shared types, keyword tables and byte classes for the keyword matcher.
package kwm_pkg;

  localparam int unsigned KwCount = 4;
  localparam int unsigned PosW    = 3;
  localparam int unsigned CodeW   = 3;

  typedef enum logic [CodeW-1:0] {
    CMD_NONE  = 3'd0,
    CMD_START = 3'd1,
    CMD_STOP  = 3'd2,
    CMD_INFO  = 3'd3,
    CMD_SNAP  = 3'd4
  } cmd_e;

  typedef struct packed {
    logic               skipping_blanks;
    logic [PosW-1:0]    match_position;
    logic [KwCount-1:0] keywords_alive;
    cmd_e               decided_code;
    logic               decision_final;
  } kwm_state_t;

  localparam kwm_state_t StateReset = '{
    skipping_blanks: 1'b1,
    match_position:  '0,
    keywords_alive:  '1,
    decided_code:    CMD_NONE,
    decision_final:  1'b0
  };

  function automatic logic is_blank(input logic [7:0] c);
    return c inside {8'h20, 8'h09, 8'h0d, 8'h0a};
  endfunction

  function automatic logic [7:0] fold_upper(input logic [7:0] c);
    if (c inside {[8'h61:8'h7a]}) begin
      return c - 8'h20;
    end
    return c;
  endfunction

  function automatic logic [PosW-1:0] kw_len(input logic [1:0] k);
    case (k)
      2'd0:    return 3'd5;
      default: return 3'd4;
    endcase
  endfunction

  function automatic logic [7:0] kw_char(input logic [1:0] k, input logic [PosW-1:0] p);
    logic [39:0] text;
    case (k)
      2'd0:    text = {"S", "T", "A", "R", "T"};
      2'd1:    text = {"S", "T", "O", "P", 8'h00};
      2'd2:    text = {"I", "N", "F", "O", 8'h00};
      default: text = {"S", "N", "A", "P", 8'h00};
    endcase
    case (p)
      3'd0:    return text[39:32];
      3'd1:    return text[31:24];
      3'd2:    return text[23:16];
      3'd3:    return text[15:8];
      3'd4:    return text[7:0];
      default: return 8'h00;
    endcase
  endfunction

endpackage

// ===== rtl/text_command_keyword_matcher.sv =====
// The accepted last byte beat passes the input register and then the result register to its command_code beat.
// Throughput: one byte beat per cycle; in_stall rises only while out_stall holds a result.
// Stages: input register, keyword compare step, result register.
// Reset: synchronous rst clears both stages and returns match state to leading-blank skip.
// Match state also returns to reset after every last byte.
module text_command_keyword_matcher (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [7:0]                 rx_byte,
  input  logic                       last_byte,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [kwm_pkg::CodeW-1:0]  command_code
);
  import kwm_pkg::*;

  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       s1_last;
  logic       s1_go;
  logic       out_free;
  logic       fire;
  cmd_e       code;

  assign out_free = !out_valid || !out_stall;
  assign s1_go    = s1_valid && (!s1_last || out_free);
  assign in_stall = s1_valid && !s1_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_byte <= rx_byte;
      s1_last <= last_byte;
    end
  end

  kwm_core u_core (
    .clk       (clk),
    .rst       (rst),
    .step_en   (s1_go),
    .rx_byte   (s1_byte),
    .last_byte (s1_last),
    .fire      (fire),
    .code      (code)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s1_go && fire;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && s1_go && fire) begin
      command_code <= code;
    end
  end

endmodule

// ===== rtl/kwm_core.sv =====
// Per-byte keyword compare step and the packet match state register.
module kwm_core (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      step_en,
  input  logic [7:0]                rx_byte,
  input  logic                      last_byte,
  output logic                      fire,
  output kwm_pkg::cmd_e             code
);
  import kwm_pkg::*;

  kwm_state_t st;
  kwm_state_t st_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= StateReset;
    end else if (step_en) begin
      st <= st_next;
    end
  end

  always_comb begin
    logic [7:0]         up;
    logic [KwCount-1:0] kill;
    logic [KwCount-1:0] hit;
    logic               active;
    logic               term;
    kwm_state_t         upd;
    upd    = st;
    fire   = 1'b0;
    code   = CMD_NONE;
    kill   = '0;
    hit    = '0;
    up     = fold_upper(rx_byte);
    term   = (rx_byte == 8'h00) || is_blank(rx_byte);
    active = !st.decision_final && !(st.skipping_blanks && is_blank(rx_byte));
    for (int k = 0; k < KwCount; k++) begin
      if (st.keywords_alive[k]) begin
        if (st.match_position < kw_len(2'(k))) begin
          kill[k] = (up != kw_char(2'(k), st.match_position));
        end else if (st.match_position == kw_len(2'(k)) && term) begin
          hit[k] = 1'b1;
        end else begin
          kill[k] = 1'b1;
        end
      end
    end
    if (active) begin
      upd.skipping_blanks = 1'b0;
      upd.keywords_alive  = st.keywords_alive & ~kill;
      if (hit != '0) begin
        upd.decision_final = 1'b1;
        for (int k = KwCount - 1; k >= 0; k--) begin
          if (hit[k]) begin
            upd.decided_code = cmd_e'(CodeW'(k + 1));
          end
        end
      end else if (upd.keywords_alive == '0) begin
        upd.decision_final = 1'b1;
        upd.decided_code   = CMD_NONE;
      end
      if (st.match_position != '1) begin
        upd.match_position = st.match_position + 1'b1;
      end
    end
    st_next = upd;
    if (last_byte) begin
      fire = 1'b1;
      if (upd.decision_final) begin
        code = upd.decided_code;
      end else if (!upd.skipping_blanks) begin
        for (int k = KwCount - 1; k >= 0; k--) begin
          if (upd.keywords_alive[k] && kw_len(2'(k)) == upd.match_position) begin
            code = cmd_e'(CodeW'(k + 1));
          end
        end
      end
      st_next = StateReset;
    end
  end

  a_done_not_skipping: assert property (@(posedge clk) disable iff (rst)
    st.decision_final |-> !st.skipping_blanks)
    else $error("decision set while still skipping blanks");

  a_pos_after_blanks: assert property (@(posedge clk) disable iff (rst)
    !st.skipping_blanks |-> st.match_position != '0)
    else $error("compare started without advancing position");

  a_reset_after_packet: assert property (@(posedge clk) disable iff (rst)
    (step_en && last_byte) |=> (st == StateReset))
    else $error("match state not cleared after last beat");

  a_code_range: assert property (@(posedge clk) disable iff (rst)
    fire |-> (code <= CMD_SNAP))
    else $error("command code out of range");

endmodule

// ===== tb/kwm_command_checker.sv =====
// Checker for the keyword matcher: predicts command codes from accepted byte beats and compares.
`timescale 1ns / 1ps

module kwm_command_checker (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  input  logic                      in_stall,
  input  logic [7:0]                rx_byte,
  input  logic                      last_byte,
  input  logic                      out_valid,
  input  logic                      out_stall,
  input  logic [kwm_pkg::CodeW-1:0] command_code,
  output int                        fail_count,
  output int                        pending_codes
);

  localparam logic [7:0] ChNul = 8'h00;
  localparam logic [7:0] ChTab = 8'h09;
  localparam logic [7:0] ChLf  = 8'h0a;
  localparam logic [7:0] ChCr  = 8'h0d;
  localparam logic [7:0] ChSp  = 8'h20;

  logic          skip_lead;
  logic [2:0]    position;
  logic [3:0]    alive;
  kwm_pkg::cmd_e chosen;
  logic          settled;

  kwm_pkg::cmd_e expected_codes[$];
  kwm_pkg::cmd_e want;
  int            errors = 0;
  int            expected_left = 0;

  assign fail_count    = errors;
  assign pending_codes = expected_left;

  function automatic string keyword_word(input int k);
    case (k)
      0:       return "START";
      1:       return "STOP";
      2:       return "INFO";
      default: return "SNAP";
    endcase
  endfunction

  function automatic logic blank_byte(input logic [7:0] c);
    return c == ChSp || c == ChTab || c == ChCr || c == ChLf;
  endfunction

  task automatic clear_match();
    skip_lead = 1'b1;
    position  = 3'd0;
    alive     = 4'hf;
    chosen    = kwm_pkg::CMD_NONE;
    settled   = 1'b0;
  endtask

  task automatic match_byte(input logic [7:0] c, input logic lst);
    logic [7:0]    up;
    string         w;
    kwm_pkg::cmd_e code;
    logic          found;
    if (!settled && !(skip_lead && blank_byte(c))) begin
      up = (c >= "a" && c <= "z") ? c - 8'h20 : c;
      skip_lead = 1'b0;
      for (int k = 0; k < 4; k++) begin
        w = keyword_word(k);
        if (alive[k] && !settled) begin
          if (position < w.len()) begin
            if (up != w[position]) alive[k] = 1'b0;
          end else if (position == w.len() && (c == ChNul || blank_byte(c))) begin
            chosen  = kwm_pkg::cmd_e'(3'(k + 1));
            settled = 1'b1;
          end else begin
            alive[k] = 1'b0;
          end
        end
      end
      if (!settled && alive == 4'h0) begin
        chosen  = kwm_pkg::CMD_NONE;
        settled = 1'b1;
      end
      if (position != 3'd7) position = position + 3'd1;
    end
    if (lst) begin
      code  = kwm_pkg::CMD_NONE;
      found = 1'b0;
      if (settled) begin
        code = chosen;
      end else if (!skip_lead) begin
        for (int k = 0; k < 4; k++) begin
          w = keyword_word(k);
          if (!found && alive[k] && w.len() == position) begin
            code  = kwm_pkg::cmd_e'(3'(k + 1));
            found = 1'b1;
          end
        end
      end
      expected_codes.push_back(code);
      clear_match();
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      clear_match();
      expected_codes.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_codes.size() == 0) begin
          $display("%0t: command_code expected none, actual %0d", $time, command_code);
          errors++;
        end else begin
          want = expected_codes.pop_front();
          if (command_code !== want) begin
            $display("%0t: command_code expected %0d, actual %0d", $time, want, command_code);
            errors++;
          end
        end
      end
      if (in_valid && !in_stall) match_byte(rx_byte, last_byte);
    end
    expected_left = expected_codes.size();
  end

endmodule

// ===== tb/text_command_keyword_matcher_tb.sv =====
// Testbench top for the keyword matcher: drives byte packets and stalls, gives the verdict.
`timescale 1ns / 1ps

module text_command_keyword_matcher_tb;

  localparam int         ByteTarget = 650;
  localparam int         CalmAfter  = 560;
  localparam int         IdleLimit  = 1000;
  localparam logic [7:0] ChNul = 8'h00;
  localparam logic [7:0] ChTab = 8'h09;
  localparam logic [7:0] ChLf  = 8'h0a;
  localparam logic [7:0] ChCr  = 8'h0d;
  localparam logic [7:0] ChSp  = 8'h20;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic [7:0]                rx_byte = 8'h00;
  logic                      last_byte = 1'b0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic [kwm_pkg::CodeW-1:0] command_code;

  int         fail_count;
  int         pending_codes;
  int         beats_sent = 0;
  int         idle_cycles = 0;
  bit         idling = 1'b1;
  logic [7:0] pkt[$];

  always #5 clk = ~clk;

  text_command_keyword_matcher u_top (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .rx_byte      (rx_byte),
    .last_byte    (last_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .command_code (command_code)
  );

  kwm_command_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .rx_byte       (rx_byte),
    .last_byte     (last_byte),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .command_code  (command_code),
    .fail_count    (fail_count),
    .pending_codes (pending_codes)
  );

  function automatic logic [7:0] pick_blank();
    case ($urandom_range(0, 3))
      0:       return ChSp;
      1:       return ChTab;
      2:       return ChCr;
      default: return ChLf;
    endcase
  endfunction

  task automatic send_beat(input logic [7:0] b, input logic lst);
    if (idling && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_valid  <= 1'b1;
    rx_byte   <= b;
    last_byte <= lst;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    beats_sent++;
  endtask

  task automatic send_packet();
    for (int i = 0; i < pkt.size(); i++) send_beat(pkt[i], i == pkt.size() - 1);
  endtask

  task automatic build_random_packet();
    int         kind;
    int         n;
    string      w;
    logic [7:0] ch;
    pkt.delete();
    kind = $urandom_range(0, 9);
    if (kind < 2) begin
      n = $urandom_range(1, 6);
      repeat (n) begin
        ch = 8'($urandom_range(0, 255));
        pkt.push_back(ch);
      end
    end else begin
      repeat ($urandom_range(0, 3)) pkt.push_back(pick_blank());
      case ($urandom_range(0, 3))
        0:       w = "START";
        1:       w = "STOP";
        2:       w = "INFO";
        default: w = "SNAP";
      endcase
      n = (kind == 2) ? $urandom_range(1, w.len() - 1) : w.len();
      for (int i = 0; i < n; i++) begin
        ch = w[i];
        if ($urandom_range(0, 1)) ch = ch | 8'h20;
        pkt.push_back(ch);
      end
      if (kind == 3) begin
        ch = 8'($urandom_range(0, 255));
        pkt[$urandom_range(0, pkt.size() - 1)] = ch;
      end
      if (kind != 2) begin
        case ($urandom_range(0, 3))
          0:       ;
          1:       pkt.push_back(ChNul);
          2:       pkt.push_back(pick_blank());
          default: begin
            ch = 8'($urandom_range(0, 255));
            pkt.push_back(ch);
          end
        endcase
      end
      repeat ($urandom_range(0, 3)) begin
        ch = 8'($urandom_range(0, 255));
        pkt.push_back(ch);
      end
    end
  endtask

  initial begin
    forever begin
      @(posedge clk);
      if (idling && $urandom_range(0, 9) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    pkt = '{ChCr, ChLf, "s", "t", "a", "r", "t"};
    send_packet();
    pkt = '{"I", "n", "f", "o", ChNul, "x"};
    send_packet();
    pkt = '{"S", "n", "a", "P", "q"};
    send_packet();
    pkt = '{"S", "T"};
    send_packet();
    pkt = '{ChNul};
    send_packet();
    pkt = '{ChSp};
    send_packet();
    pkt = '{8'hff};
    send_packet();
    pkt = '{"s", "t", "o", "p", ChTab};
    send_packet();

    while (beats_sent < ByteTarget) begin
      build_random_packet();
      send_packet();
      if (beats_sent > CalmAfter) idling = 1'b0;
    end
    in_valid <= 1'b0;

    @(posedge clk);
    while (pending_codes != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (fail_count == 0 && pending_codes == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
